/* design/rgbhsl_pkg.sv */
// Shared types and constants for the RGB to HSL converter.
`default_nettype none
package rgbhsl_pkg;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int FRACTION_BITS_MAX = 24;
	localparam int QUO_W = FRACTION_BITS_MAX + 1;
	localparam int REM_W = FRACTION_BITS_MAX + 12;
	localparam int HDIV_W = 12;
	localparam int SDIV_W = 10;
	localparam int LIGHT_DIV = 1020;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [15:0] hue;
		logic [15:0] saturation;
		logic [15:0] lightness;
	} hsl_t;

	typedef struct packed {
		logic              chroma;
		logic [REM_W-1:0]  rem_h;
		logic [REM_W-1:0]  rem_s;
		logic [REM_W-1:0]  rem_l;
		logic [HDIV_W-1:0] div_h;
		logic [SDIV_W-1:0] div_s;
		logic [QUO_W-1:0]  q_h;
		logic [QUO_W-1:0]  q_s;
		logic [QUO_W-1:0]  q_l;
	} cell_t;
endpackage
`default_nettype wire

/* design/rgbhsl_front.sv */
// Extremes, sector numerator and divider operands for one pixel.
`default_nettype none
module rgbhsl_front #(
	parameter int FRACTION_BITS = rgbhsl_pkg::FRACTION_BITS_DEF
) (
	input  rgbhsl_pkg::pixel_t pix,
	output rgbhsl_pkg::cell_t  ops
);
	import rgbhsl_pkg::*;

	logic [7:0]  hi, lo, d, den;
	logic [8:0]  sum;
	logic [10:0] n;
	logic [10:0] d6;
	logic [REM_W-1:0] dw, sw;

	always_comb begin
		hi = pix.red;
		lo = pix.red;
		if (pix.green > hi) hi = pix.green;
		if (pix.blue > hi) hi = pix.blue;
		if (pix.green < lo) lo = pix.green;
		if (pix.blue < lo) lo = pix.blue;
		sum = {1'b0, hi} + {1'b0, lo};
		d = hi - lo;
		den = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
		d6 = 11'(d) * 11'd6;
		if (hi == pix.red) begin
			if (pix.green >= pix.blue) n = 11'(pix.green - pix.blue);
			else n = d6 - 11'(pix.blue - pix.green);
		end else if (hi == pix.green) begin
			n = (11'(d) << 1) + 11'(pix.blue) - 11'(pix.red);
		end else begin
			n = (11'(d) << 2) + 11'(pix.red) - 11'(pix.green);
		end
		dw = REM_W'(d);
		sw = REM_W'(sum);
		ops.chroma = (hi != lo);
		ops.rem_h = (REM_W'(n) << (FRACTION_BITS + 1)) + REM_W'(d6);
		ops.rem_s = (((dw << FRACTION_BITS) - dw) << 1) + REM_W'(den);
		ops.rem_l = (((sw << FRACTION_BITS) - sw) << 1) + REM_W'(510);
		ops.div_h = HDIV_W'(d6) << 1;
		ops.div_s = SDIV_W'(den) << 1;
		ops.q_h = '0;
		ops.q_s = '0;
		ops.q_l = '0;
	end
endmodule
`default_nettype wire

/* design/rgbhsl_cell.sv */
// One quotient bit of the hue, saturation and lightness dividers.
`default_nettype none
module rgbhsl_cell #(
	parameter int BIT = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  rgbhsl_pkg::cell_t in_data,
	input  logic              next_ready,
	output logic              ready,
	output logic              valid,
	output rgbhsl_pkg::cell_t data
);
	import rgbhsl_pkg::*;

	logic       valid_q;
	cell_t      data_q;
	cell_t      nxt;
	logic [REM_W-1:0] sh_h, sh_s, sh_l;
	logic       ge_h, ge_s, ge_l;

	assign ready = !valid_q || next_ready;
	assign valid = valid_q;
	assign data  = data_q;

	always_comb begin
		sh_h = REM_W'(in_data.div_h) << BIT;
		sh_s = REM_W'(in_data.div_s) << BIT;
		sh_l = REM_W'(LIGHT_DIV) << BIT;
		ge_h = in_data.rem_h >= sh_h;
		ge_s = in_data.rem_s >= sh_s;
		ge_l = in_data.rem_l >= sh_l;
		nxt = in_data;
		nxt.rem_h = ge_h ? in_data.rem_h - sh_h : in_data.rem_h;
		nxt.rem_s = ge_s ? in_data.rem_s - sh_s : in_data.rem_s;
		nxt.rem_l = ge_l ? in_data.rem_l - sh_l : in_data.rem_l;
		nxt.q_h = {in_data.q_h[QUO_W-2:0], ge_h};
		nxt.q_s = {in_data.q_s[QUO_W-2:0], ge_s};
		nxt.q_l = {in_data.q_l[QUO_W-2:0], ge_l};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && in_valid) begin
			data_q <= nxt;
		end
	end
endmodule
`default_nettype wire

/* design/rgb_to_hsl_converter.sv */
// Top level of the RGB to HSL converter.
// Converts one 8-bit RGB pixel per clock while not stalled to hue, saturation and lightness
// as 16-bit fractions rounded to nearest. Each request passes a chain of FRACTION_BITS+1
// divider cells, one quotient bit per cell, and a new pixel is taken every cycle unless
// a full pipeline is held by result stall. Cells hold their contents on result stall, and
// empty cells keep filling while the output waits.
`default_nettype none
module rgb_to_hsl_converter #(
	parameter int FRACTION_BITS = rgbhsl_pkg::FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pixel_valid,
	output logic               pixel_stall,
	input  rgbhsl_pkg::pixel_t pixel,
	output logic               result_valid,
	input  logic               result_stall,
	output rgbhsl_pkg::hsl_t   result
);
	import rgbhsl_pkg::*;

	localparam int NCELL = FRACTION_BITS + 1;

	cell_t            front_ops;
	cell_t            cdata [NCELL];
	logic [NCELL-1:0] cvalid;
	logic [NCELL-1:0] cready;
	cell_t            last;
	logic [FRACTION_BITS-1:0] hq, sq, lq;

	rgbhsl_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
		.pix(pixel),
		.ops(front_ops)
	);

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		rgbhsl_cell #(.BIT(NCELL - 1 - k)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  ((k == 0) ? pixel_valid : cvalid[(k == 0) ? 0 : k - 1]),
			.in_data   ((k == 0) ? front_ops : cdata[(k == 0) ? 0 : k - 1]),
			.next_ready((k == NCELL - 1) ? !result_stall : cready[(k == NCELL - 1) ? k : k + 1]),
			.ready     (cready[k]),
			.valid     (cvalid[k]),
			.data      (cdata[k])
		);
	end

	assign last         = cdata[NCELL-1];
	assign pixel_stall  = !cready[0];
	assign result_valid = cvalid[NCELL-1];
	assign hq = last.q_h[FRACTION_BITS-1:0];
	assign sq = last.q_s[FRACTION_BITS-1:0];
	assign lq = last.q_l[FRACTION_BITS-1:0];

	always_comb begin
		result.hue        = last.chroma ? 16'(hq) : 16'd0;
		result.saturation = last.chroma ? 16'(sq) : 16'd0;
		result.lightness  = 16'(lq);
	end

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!cvalid[NCELL-1] |-> !pixel_stall)
		else $error("pipeline stalls input with an empty output cell");
	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last.chroma) |-> (last.q_s[FRACTION_BITS] == 1'b0))
		else $error("saturation quotient exceeds full scale");
	a_light_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (last.q_l[FRACTION_BITS] == 1'b0))
		else $error("lightness quotient exceeds full scale");
endmodule
`default_nettype wire

/* test/rgb_to_hsl_converter_tb.sv */
// Testbench for the RGB to HSL converter: random and corner pixels checked against a predictor.
`timescale 1ns / 1ps
module rgb_to_hsl_converter_tb;
	import rgbhsl_pkg::*;

	localparam int FB = FRACTION_BITS_DEF;
	localparam int N_RANDOM = 1330;
	localparam int STALL_LIMIT = 2000;

	class hsl_scoreboard;
		hsl_t pending[$];
		int errors;

		function hsl_t convert(pixel_t p);
			longint unsigned r, g, b, hi, lo, sum, d, n, den, one, full;
			hsl_t o;
			r = p.red;
			g = p.green;
			b = p.blue;
			one = 64'd1 << FB;
			full = one - 1;
			hi = r;
			lo = r;
			if (g > hi) hi = g;
			if (b > hi) hi = b;
			if (g < lo) lo = g;
			if (b < lo) lo = b;
			sum = hi + lo;
			o.lightness = 16'((2 * sum * full + 510) / 1020);
			o.hue = '0;
			o.saturation = '0;
			if (hi != lo) begin
				d = hi - lo;
				den = (sum <= 255) ? sum : 510 - sum;
				o.saturation = 16'((2 * d * full + den) / (2 * den));
				if (hi == r) begin
					n = g + d - b - d;
					if (g < b) n += 6 * d;
				end else if (hi == g) begin
					n = b + 2 * d - r;
				end else begin
					n = r + 4 * d - g;
				end
				o.hue = 16'(((2 * n * one + 6 * d) / (12 * d)) & full);
			end
			return o;
		endfunction

		function void note_pixel(pixel_t p);
			pending.push_back(convert(p));
		endfunction

		function void check_result(hsl_t got);
			hsl_t exp;
			if (pending.size() == 0) begin
				$display("%0t unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.hue !== exp.hue) begin
				$display("%0t hue expected %h actual %h", $time, exp.hue, got.hue);
				errors++;
			end
			if (got.saturation !== exp.saturation) begin
				$display("%0t saturation expected %h actual %h", $time, exp.saturation,
					got.saturation);
				errors++;
			end
			if (got.lightness !== exp.lightness) begin
				$display("%0t lightness expected %h actual %h", $time, exp.lightness,
					got.lightness);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic pixel_valid = 0;
	logic pixel_stall;
	pixel_t pixel = '0;
	logic result_valid;
	logic result_stall = 0;
	hsl_t result;
	hsl_scoreboard board = new();
	int idle_cycles = 0;
	int out_wait = 0;
	bit sending_done = 0;

	rgb_to_hsl_converter dut (
		.clk(clk), .arst_n(arst_n),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	task automatic send_pixel(pixel_t p);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			pixel_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1;
		pixel <= p;
		do @(posedge clk); while (pixel_stall);
		board.note_pixel(p);
	endtask

	task automatic send_all();
		pixel_t corners[$];
		pixel_t p;
		corners = '{{8'd0, 8'd0, 8'd0}, {8'd255, 8'd255, 8'd255}, {8'd128, 8'd128, 8'd128},
			{8'd255, 8'd0, 8'd0}, {8'd0, 8'd255, 8'd0}, {8'd0, 8'd0, 8'd255},
			{8'd255, 8'd255, 8'd0}, {8'd0, 8'd255, 8'd255}, {8'd255, 8'd0, 8'd255},
			{8'd255, 8'd0, 8'd1}, {8'd255, 8'd0, 8'd254}, {8'd255, 8'd1, 8'd0},
			{8'd1, 8'd0, 8'd0}, {8'd128, 8'd127, 8'd127}, {8'd127, 8'd128, 8'd128},
			{8'd255, 8'd254, 8'd254}, {8'd0, 8'd1, 8'd1}, {8'd200, 8'd100, 8'd50},
			{8'd50, 8'd200, 8'd100}, {8'd100, 8'd50, 8'd200}, {8'd10, 8'd10, 8'd9},
			{8'd255, 8'd0, 8'd255}, {8'd170, 8'd85, 8'd255}};
		foreach (corners[i]) send_pixel(corners[i]);
		for (int i = 0; i < N_RANDOM; i++) begin
			p = pixel_t'($urandom);
			case ($urandom_range(0, 5))
				0: p.green = p.red;
				1: p.blue = p.green;
				2: begin
					p.green = p.red;
					p.blue = p.red;
				end
				default: ;
			endcase
			send_pixel(p);
		end
		pixel_valid <= 0;
		sending_done = 1;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				board.check_result(result);
				out_wait = $urandom_range(0, 14);
			end else if (out_wait > 0) begin
				out_wait = out_wait - 1;
			end
			result_stall <= out_wait > 0;
		end
	end

	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_all();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (FB + 20) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
